/* hw/rtl/sorted_table_search_unit_assert.svh */
// ----------------------------------------------------------------------------
// Sorted table search assertion macros
// Shorthand for concurrent checks clocked by clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_SEARCH_UNIT_ASSERT_SVH
`define SORTED_TABLE_SEARCH_UNIT_ASSERT_SVH

// Same-cycle implication.
`define STS_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define STS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/sts_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted table search package
// Widths, command and status codes, state type and divider control.
// ----------------------------------------------------------------------------
package sts_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int VALUE_W     = 32;
   localparam int STATUS_W    = 2;
   // signed table position, holds -1 and TABLE_DEPTH
   localparam int POS_W       = IDX_W + 2;
   // differences of two entries
   localparam int NUM_W       = VALUE_W + 1;
   localparam int PROD_W      = NUM_W + POS_W;
   // quotient magnitude never exceeds the slice span
   localparam int QUOT_W      = IDX_W + 1;
   localparam int DIVISOR_W   = NUM_W;
   localparam int DIVIDEND_W  = DIVISOR_W + QUOT_W - 1;
   localparam int CNT_W       = $clog2(QUOT_W + 1);

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   localparam logic MODE_BINARY = 1'b0;

   localparam logic [STATUS_W-1:0] STATUS_FOUND     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BOUNDS    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_UNSORTED  = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_BIN_PROBE,
      S_BIN_CMP,
      S_INT_RD_LO,
      S_INT_RD_HI,
      S_INT_CHECK,
      S_INT_MUL,
      S_INT_DIV_GO,
      S_INT_DIV_WAIT,
      S_INT_PROBE,
      S_INT_CMP,
      S_DONE
   } sts_state_type;

   typedef struct packed {
      logic start;
      logic negate;
   } sts_div_ctl_type;

endpackage

/* hw/rtl/sts_div.sv */
// ----------------------------------------------------------------------------
// Sorted table search divider
// Restoring divider on magnitudes, one quotient bit per cycle, signed result.
// ----------------------------------------------------------------------------
module sts_div (
   input  logic                              clock,
   input  logic                              reset,
   input  sts_pkg::sts_div_ctl_type          div_ctl,
   input  logic [sts_pkg::DIVIDEND_W-1:0]    dividend,
   input  logic [sts_pkg::DIVISOR_W-1:0]     divisor,
   output logic                              div_done,
   output logic signed [sts_pkg::POS_W-1:0]  quotient
);
   import sts_pkg::*;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0]  dsh_ff, dsh_in;
   logic [QUOT_W-1:0]      quo_ff, quo_in;
   logic                   neg_ff, neg_in;
   logic                   fits;
   logic signed [POS_W-1:0] quo_ext;

   assign fits = rem_ff >= dsh_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      if (div_ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(QUOT_W);
         rem_in  = dividend;
         dsh_in  = DIVIDEND_W'({divisor, {(QUOT_W-1){1'b0}}});
         quo_in  = '0;
         neg_in  = div_ctl.negate;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - dsh_ff;
         end
         quo_in = {quo_ff[QUOT_W-2:0], fits};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
   end

   assign quo_ext  = signed'(POS_W'(quo_ff));
   assign quotient = neg_ff ? -quo_ext : quo_ext;
   assign div_done = done_ff;

endmodule

/* hw/rtl/sorted_table_search_unit.sv */
// ----------------------------------------------------------------------------
// Sorted table search unit
// Table of signed entries in one synchronous memory; binary or
// interpolation search over a slice of it, one request at a time.
// ----------------------------------------------------------------------------
// Load: written from idle, next request taken in the following cycle, no result.
// Binary search: each probe is a memory read, then a compare, until a hit or
//   the bounds cross; the result is then posted from the done state.
// Interpolation search: per probe, read both slice ends, check, multiply, divide,
//   read the probe; paced by the divider done flag and the single memory read port.
// Reset clears control and selects binary search; table undefined until loaded.
module sorted_table_search_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_cmd,
   input  logic [sts_pkg::IDX_W-1:0]          req_entry_index,
   input  logic signed [sts_pkg::VALUE_W-1:0] req_entry_value,
   input  logic signed [sts_pkg::VALUE_W-1:0] req_search_key,
   input  logic [sts_pkg::IDX_W-1:0]          req_slice_low,
   input  logic [sts_pkg::IDX_W-1:0]          req_slice_high,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [sts_pkg::STATUS_W-1:0]       rsp_status,
   output logic [sts_pkg::IDX_W-1:0]          rsp_found_index,
   input  logic                               csr_write_en,
   input  logic                               csr_write_data
);
   import sts_pkg::*;

   sts_state_type state_ff, state_in;
   logic          mode_ff;

   logic signed [VALUE_W-1:0] key_ff, key_in;
   logic signed [POS_W-1:0]   lo_ff, lo_in;
   logic signed [POS_W-1:0]   hi_ff, hi_in;
   logic signed [POS_W-1:0]   probe_ff, probe_in;
   logic signed [VALUE_W-1:0] lv_ff, lv_in;
   logic signed [VALUE_W-1:0] hv_ff, hv_in;
   logic signed [NUM_W-1:0]   num_ff, num_in;
   logic signed [NUM_W-1:0]   den_ff, den_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic [STATUS_W-1:0]       res_status_ff, res_status_in;
   logic [IDX_W-1:0]          res_index_ff, res_index_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]          rsp_index_ff, rsp_index_in;

   logic [VALUE_W-1:0]        entry_mem [TABLE_DEPTH];
   logic [VALUE_W-1:0]        rd_data_ff;
   logic                      rd_oob_ff;
   logic signed [POS_W-1:0]   rd_addr;
   logic                      rd_oob;
   logic signed [VALUE_W-1:0] rd_value;
   logic                      mem_we;

   logic                      req_accept;
   logic                      out_free;
   logic signed [POS_W:0]     bin_sum;
   logic signed [POS_W-1:0]   bin_mid;
   logic                      hit;
   logic                      lo_above_hi;
   logic signed [VALUE_W-1:0] end_min, end_max;
   logic                      ends_equal, key_outside;
   logic signed [POS_W-1:0]   span;
   logic signed [PROD_W-1:0]  prod_abs;
   logic signed [NUM_W-1:0]   den_abs;
   logic signed [POS_W-1:0]   int_probe;
   logic                      int_stop;

   sts_div_ctl_type           div_ctl;
   logic                      div_done;
   logic signed [POS_W-1:0]   div_quot;

   sts_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_ctl  (div_ctl),
      .dividend (prod_abs[DIVIDEND_W-1:0]),
      .divisor  (den_abs),
      .div_done (div_done),
      .quotient (div_quot)
   );

   assign req_stall  = state_ff != S_IDLE;
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // positions outside the table read as zero
   assign rd_oob   = (rd_addr < 0) || (rd_addr >= POS_W'(TABLE_DEPTH));
   assign rd_value = rd_oob_ff ? '0 : signed'(rd_data_ff);

   assign bin_sum     = (POS_W+1)'(lo_ff) + (POS_W+1)'(hi_ff);
   assign bin_mid     = signed'(bin_sum[POS_W:1]);
   assign hit         = rd_value == key_ff;
   assign lo_above_hi = lo_ff > hi_ff;

   assign end_min     = (lv_ff < rd_value) ? lv_ff : rd_value;
   assign end_max     = (lv_ff < rd_value) ? rd_value : lv_ff;
   assign ends_equal  = lv_ff == rd_value;
   assign key_outside = (key_ff < end_min) || (key_ff > end_max);
   assign span        = hi_ff - lo_ff;

   assign prod_abs  = prod_ff[PROD_W-1] ? -prod_ff : prod_ff;
   assign den_abs   = den_ff[NUM_W-1] ? -den_ff : den_ff;
   assign int_probe = lo_ff + div_quot;
   assign int_stop  = hit || (lo_ff == probe_ff) || lo_above_hi || (lv_ff > hv_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept && req_cmd == CMD_SEARCH) begin
               state_in = (mode_ff == MODE_BINARY) ? S_BIN_PROBE : S_INT_RD_LO;
            end
         end
         S_BIN_PROBE:    state_in = lo_above_hi ? S_DONE : S_BIN_CMP;
         S_BIN_CMP:      state_in = hit ? S_DONE : S_BIN_PROBE;
         S_INT_RD_LO:    state_in = S_INT_RD_HI;
         S_INT_RD_HI:    state_in = S_INT_CHECK;
         S_INT_CHECK:    state_in = (ends_equal || key_outside) ? S_DONE : S_INT_MUL;
         S_INT_MUL:      state_in = S_INT_DIV_GO;
         S_INT_DIV_GO:   state_in = S_INT_DIV_WAIT;
         S_INT_DIV_WAIT: state_in = div_done ? S_INT_PROBE : S_INT_DIV_WAIT;
         S_INT_PROBE:    state_in = S_INT_CMP;
         S_INT_CMP:      state_in = int_stop ? S_DONE : S_INT_RD_LO;
         S_DONE:         state_in = out_free ? S_IDLE : S_DONE;
         default:        state_in = S_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      key_in         = key_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      probe_in       = probe_ff;
      lv_in          = lv_ff;
      hv_in          = hv_ff;
      num_in         = num_ff;
      den_in         = den_ff;
      prod_in        = prod_ff;
      res_status_in  = res_status_ff;
      res_index_in   = res_index_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_index_in   = rsp_index_ff;
      rd_addr        = lo_ff;
      mem_we         = 1'b0;
      div_ctl.start  = 1'b0;
      div_ctl.negate = prod_ff[PROD_W-1] ^ den_ff[NUM_W-1];
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_cmd == CMD_LOAD) begin
                  mem_we = 1'b1;
               end else begin
                  key_in = req_search_key;
                  lo_in  = signed'(POS_W'(req_slice_low));
                  hi_in  = signed'(POS_W'(req_slice_high));
               end
            end
         end
         S_BIN_PROBE: begin
            rd_addr  = bin_mid;
            probe_in = bin_mid;
            if (lo_above_hi) begin
               res_status_in = STATUS_NOT_FOUND;
               res_index_in  = '0;
            end
         end
         S_BIN_CMP: begin
            if (hit) begin
               res_status_in = STATUS_FOUND;
               res_index_in  = probe_ff[IDX_W-1:0];
            end else if (rd_value < key_ff) begin
               lo_in = probe_ff + POS_W'(1);
            end else begin
               hi_in = probe_ff - POS_W'(1);
            end
         end
         S_INT_RD_LO: begin
            rd_addr = lo_ff;
         end
         S_INT_RD_HI: begin
            rd_addr = hi_ff;
            lv_in   = rd_value;
         end
         S_INT_CHECK: begin
            hv_in  = rd_value;
            num_in = NUM_W'(key_ff) - NUM_W'(lv_ff);
            den_in = NUM_W'(rd_value) - NUM_W'(lv_ff);
            if (ends_equal) begin
               if (key_ff == lv_ff) begin
                  res_status_in = STATUS_FOUND;
                  res_index_in  = lo_ff[IDX_W-1:0];
               end else begin
                  res_status_in = STATUS_NOT_FOUND;
                  res_index_in  = '0;
               end
            end else if (key_outside) begin
               res_status_in = STATUS_NOT_FOUND;
               res_index_in  = '0;
            end
         end
         S_INT_MUL: begin
            prod_in = PROD_W'(num_ff) * PROD_W'(span);
         end
         S_INT_DIV_GO: begin
            div_ctl.start = 1'b1;
         end
         S_INT_PROBE: begin
            rd_addr  = int_probe;
            probe_in = int_probe;
         end
         S_INT_CMP: begin
            res_index_in = '0;
            if (hit) begin
               res_status_in = STATUS_FOUND;
               res_index_in  = probe_ff[IDX_W-1:0];
            end else if (lo_ff == probe_ff) begin
               res_status_in = STATUS_NOT_FOUND;
            end else if (lo_above_hi) begin
               res_status_in = STATUS_BOUNDS;
            end else if (lv_ff > hv_ff) begin
               res_status_in = STATUS_UNSORTED;
            end else if (key_ff < rd_value) begin
               hi_in = probe_ff - POS_W'(1);
            end else begin
               lo_in = probe_ff + POS_W'(1);
            end
         end
         S_DONE: begin
            // hold the result until the output register frees up
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_index_in  = res_index_ff;
            end
         end
         default: begin
            rd_addr = lo_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_BINARY;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            mode_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      probe_ff      <= probe_in;
      lv_ff         <= lv_in;
      hv_ff         <= hv_in;
      num_ff        <= num_in;
      den_ff        <= den_in;
      prod_ff       <= prod_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
   end

   // table memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[req_entry_index] <= req_entry_value;
      end
      rd_data_ff <= entry_mem[rd_addr[IDX_W-1:0]];
      rd_oob_ff  <= rd_oob;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_index = rsp_index_ff;

endmodule

/* hw/rtl/sts_check.sv */
// ----------------------------------------------------------------------------
// Sorted table search port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_table_search_unit_assert.svh"

module sts_check (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic                               req_cmd,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic [sts_pkg::STATUS_W-1:0]       rsp_status,
   input  logic [sts_pkg::IDX_W-1:0]          rsp_found_index
);
   import sts_pkg::*;

   logic                      req_take;
   logic                      rsp_miss;
   logic                      rsp_held;
   logic [STATUS_W+IDX_W-1:0] rsp_word;

   assign req_take = req_valid && !req_stall;
   assign rsp_miss = rsp_valid && rsp_status != STATUS_FOUND;
   assign rsp_held = rsp_valid && rsp_stall;
   assign rsp_word = {rsp_status, rsp_found_index};

   // a search request occupies the unit
   `STS_ASSERT_NEXT(a_search_busy, req_take && req_cmd == CMD_SEARCH, req_stall, "search no stall")

   // a load request leaves the unit free in the next cycle
   `STS_ASSERT_NEXT(a_load_free, req_take && req_cmd == CMD_LOAD, !req_stall, "load left stall")

   // a new response only comes out of a search in progress
   `STS_ASSERT_IMPL(a_rsp_from_search, $rose(rsp_valid), $past(req_stall), "stray response")

   // only a hit carries a position
   `STS_ASSERT_IMPL(a_index_zero, rsp_miss, rsp_found_index == '0, "miss carries an index")

   `STS_ASSERT_NEXT(a_rsp_hold, rsp_held, rsp_valid && $stable(rsp_word), "stalled response changed")

endmodule

bind sorted_table_search_unit sts_check u_sts_check (.*);
